// ----- rtl/core/lpt_pkg.sv -----
`timescale 1ns / 1ps
package lpt_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned WEIGHT_W  = 33;
  localparam int unsigned LOAD_W    = 40;
  localparam int unsigned JOB_IDX_W = 6;
  localparam int unsigned WORKER_W  = 3;
  localparam int unsigned WCNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WCNT_W-1:0]  WORKER_COUNT_RESET = 4'd8;
  localparam logic [FIELD_W-1:0] PAR_MIN_RESET      = 32'd131072;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORKER_COUNT = 1'b0,
    REG_PAR_MIN      = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_CLEAR,
    ST_SCAN,
    ST_SDONE,
    ST_PICK,
    ST_WSCAN,
    ST_WDONE,
    ST_UPD,
    ST_EMIT
  } lpt_state_e;

  // control from the sequencer to the worker load memory
  typedef struct packed {
    logic clr_en;
    logic rd_en;
    logic rd_first;
    logic upd_en;
  } pool_ctl_t;

endpackage

// ----- rtl/core/lpt_job_store.sv -----
`timescale 1ns / 1ps
module lpt_job_store #(
  parameter int unsigned MAX_JOBS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [lpt_pkg::WEIGHT_W-1:0]      wr_weight_i,
  input  logic [lpt_pkg::FIELD_W-1:0]       wr_count_i,
  input  logic                              set_clear_i,
  input  logic [$clog2(MAX_JOBS)-1:0]       rd_addr_i,
  output logic [lpt_pkg::WEIGHT_W-1:0]      rd_data_o,
  output logic [$clog2(MAX_JOBS+1)-1:0]     job_total_o,
  output logic [lpt_pkg::FIELD_W+$clog2(MAX_JOBS+1)-1:0] value_total_o
);
  import lpt_pkg::*;

  localparam int unsigned IW = $clog2(MAX_JOBS);
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned VW = FIELD_W + CW;

  logic [WEIGHT_W-1:0] mem_q [MAX_JOBS];
  logic [WEIGHT_W-1:0] rd_data_q;
  logic [CW-1:0]       total_q, total_d;
  logic [VW-1:0]       vtot_q, vtot_d;
  logic                room;

  assign room = (total_q < CW'(MAX_JOBS));

  always_comb begin
    total_d = total_q;
    vtot_d  = vtot_q;
    if (set_clear_i) begin
      total_d = '0;
      vtot_d  = '0;
    end else if (wr_en_i && room) begin
      total_d = total_q + CW'(1);
      vtot_d  = vtot_q + VW'(wr_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      vtot_q  <= '0;
    end else begin
      total_q <= total_d;
      vtot_q  <= vtot_d;
    end
  end

  // weight memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && room) begin
      mem_q[total_q[IW-1:0]] <= wr_weight_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o     = rd_data_q;
  assign job_total_o   = total_q;
  assign value_total_o = vtot_q;

endmodule

// ----- rtl/core/lpt_worker_pool.sv -----
`timescale 1ns / 1ps
module lpt_worker_pool #(
  parameter int unsigned MAX_WORKERS = 8
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  lpt_pkg::pool_ctl_t                                ctl_i,
  input  logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] addr_i,
  input  logic [lpt_pkg::WEIGHT_W-1:0]                      weight_i,
  output logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] best_o
);
  import lpt_pkg::*;

  localparam int unsigned WIW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  logic [LOAD_W-1:0] mem_q [MAX_WORKERS];
  logic [LOAD_W-1:0] rd_data_q;
  logic [WIW-1:0]    rd_idx_q;
  logic              rd_vld_q, rd_first_q;
  logic [LOAD_W-1:0] best_load_q;
  logic [WIW-1:0]    best_idx_q;
  logic [LOAD_W:0]   sum;

  // saturating load update
  assign sum = {1'b0, best_load_q} + (LOAD_W+1)'(weight_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_en) begin
      mem_q[addr_i] <= '0;
    end else if (ctl_i.upd_en) begin
      mem_q[best_idx_q] <= sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
    end
    rd_data_q <= mem_q[addr_i];
    rd_idx_q  <= addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctl_i.rd_en;
      rd_first_q <= ctl_i.rd_first;
    end
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (rd_first_q || (rd_data_q < best_load_q))) begin
      best_load_q <= rd_data_q;
      best_idx_q  <= rd_idx_q;
    end
  end

  assign best_o = best_idx_q;

endmodule

// ----- rtl/core/lpt_job_load_balancer_top.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | source_bytes, buffer_bytes, value_count, last_job
// out     | output    | out_valid_o/out_ready_i | job_index, job_weight, worker, last_result
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// jobs load at one transaction per cycle into the weight memory
// after the last job the set is assigned: each result takes one pass over the
// weight memory (one read per cycle) to find the next job by descending
// weight, then for a parallel set a pass over the load memory plus an
// update step; a serial set reads one entry
// a parallel set starts with a clear sweep of the load memory
// no input transaction is taken while a set is being assigned; a stalled
// result simply holds the sequencer in its emit state
// reset clears counters and the sequencer; memories need no reset
module lpt_job_load_balancer_top #(
  parameter int unsigned MAX_JOBS    = 64,
  parameter int unsigned MAX_WORKERS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  lpt_pkg::cfg_reg_e                  cfg_idx_i,
  input  logic [lpt_pkg::FIELD_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lpt_pkg::FIELD_W-1:0]        source_bytes_i,
  input  logic [lpt_pkg::FIELD_W-1:0]        buffer_bytes_i,
  input  logic [lpt_pkg::FIELD_W-1:0]        value_count_i,
  input  logic                               last_job_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lpt_pkg::JOB_IDX_W-1:0]      job_index_o,
  output logic [lpt_pkg::WEIGHT_W-1:0]       job_weight_o,
  output logic [lpt_pkg::WORKER_W-1:0]       worker_o,
  output logic                               last_result_o
);
  import lpt_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_JOBS);
  localparam int unsigned CW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned VW  = FIELD_W + CW;
  localparam int unsigned WIW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned WCW = $clog2(MAX_WORKERS + 1);

  lpt_state_e state_q, state_d;

  // configuration
  logic [WCNT_W-1:0]  wcnt_q;
  logic [FIELD_W-1:0] pmin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= WORKER_COUNT_RESET;
      pmin_q <= PAR_MIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WORKER_COUNT: wcnt_q <= cfg_data_i[WCNT_W-1:0];
        REG_PAR_MIN:      pmin_q <= cfg_data_i;
      endcase
    end
  end

  // job store
  logic              in_acc, out_acc;
  logic [WEIGHT_W-1:0] st_rd_data;
  logic [CW-1:0]     st_total;
  logic [VW-1:0]     st_vtot;
  logic [CW-1:0]     s_q, hi_q, k_q, n_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  lpt_job_store #(.MAX_JOBS(MAX_JOBS)) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (in_acc),
    .wr_weight_i   (WEIGHT_W'(source_bytes_i) + WEIGHT_W'(buffer_bytes_i)),
    .wr_count_i    (value_count_i),
    .set_clear_i   (state_q == ST_START),
    .rd_addr_i     (s_q[IW-1:0]),
    .rd_data_o     (st_rd_data),
    .job_total_o   (st_total),
    .value_total_o (st_vtot)
  );

  // set decisions taken once the last job is stored
  logic          serial_now;
  logic [31:0]   wk_a, wk_b, wk_c;

  assign serial_now = (st_total < CW'(2)) || (st_vtot < VW'(pmin_q));
  assign wk_a = (wcnt_q == '0) ? 32'd1 : 32'(wcnt_q);
  assign wk_b = (wk_a > 32'(MAX_WORKERS)) ? 32'(MAX_WORKERS) : wk_a;
  assign wk_c = (wk_b > 32'(st_total)) ? 32'(st_total) : wk_b;

  logic            serial_q;
  logic [WCW-1:0]  wnum_q, c_q;
  logic            last_k;

  assign last_k = (k_q == n_q - CW'(1));

  // worker load memory
  pool_ctl_t      pool_ctl;
  logic [WIW-1:0] pool_best;
  logic [WEIGHT_W-1:0] cand_w_q;
  logic [IW-1:0]  cand_i_q;

  lpt_worker_pool #(.MAX_WORKERS(MAX_WORKERS)) u_pool (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (pool_ctl),
    .addr_i   (c_q[WIW-1:0]),
    .weight_i (cand_w_q),
    .best_o   (pool_best)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && last_job_i) state_d = ST_START;
      ST_START: state_d = serial_now ? ST_SCAN : ST_CLEAR;
      ST_CLEAR: if (c_q == wnum_q - WCW'(1)) state_d = ST_SCAN;
      ST_SCAN:  if (s_q == hi_q) state_d = ST_SDONE;
      ST_SDONE: state_d = ST_PICK;
      ST_PICK:  state_d = serial_q ? ST_EMIT : ST_WSCAN;
      ST_WSCAN: if (c_q == wnum_q - WCW'(1)) state_d = ST_WDONE;
      ST_WDONE: state_d = ST_UPD;
      ST_UPD:   state_d = ST_EMIT;
      ST_EMIT:  if (out_acc) state_d = last_k ? ST_LOAD : ST_SCAN;
      default:  state_d = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o        = (state_q == ST_LOAD);
    out_valid_o       = (state_q == ST_EMIT);
    pool_ctl.clr_en   = (state_q == ST_CLEAR);
    pool_ctl.rd_en    = (state_q == ST_WSCAN);
    pool_ctl.rd_first = (state_q == ST_WSCAN) && (c_q == '0);
    pool_ctl.upd_en   = (state_q == ST_UPD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  // scan bookkeeping
  logic            rd_vld_q, found_q, have_prev_q;
  logic [IW-1:0]   rd_idx_q, prev_i_q;
  logic [WEIGHT_W-1:0] prev_w_q;
  logic            elig, take;

  // a job is still pending if it sorts after the last one emitted
  assign elig = !have_prev_q || (st_rd_data < prev_w_q) ||
                ((st_rd_data == prev_w_q) && (rd_idx_q > prev_i_q));
  assign take = rd_vld_q && elig && (!found_q || (st_rd_data > cand_w_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_q    <= 1'b0;
      wnum_q      <= '0;
      c_q         <= '0;
      s_q         <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      n_q         <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      if (take) found_q <= 1'b1;
      unique case (state_q)
        ST_START: begin
          serial_q    <= serial_now;
          wnum_q      <= wk_c[WCW-1:0];
          n_q         <= st_total;
          k_q         <= '0;
          c_q         <= '0;
          s_q         <= '0;
          hi_q        <= serial_now ? '0 : st_total - CW'(1);
          found_q     <= 1'b0;
          have_prev_q <= 1'b0;
        end
        ST_CLEAR: c_q <= (c_q == wnum_q - WCW'(1)) ? '0 : c_q + WCW'(1);
        ST_SCAN:  if (s_q != hi_q) s_q <= s_q + CW'(1);
        ST_WSCAN: if (c_q != wnum_q - WCW'(1)) c_q <= c_q + WCW'(1);
        ST_PICK:  c_q <= '0;
        ST_EMIT: begin
          if (out_acc) begin
            k_q         <= k_q + CW'(1);
            found_q     <= 1'b0;
            have_prev_q <= !serial_q;
            s_q         <= serial_q ? k_q + CW'(1) : '0;
            hi_q        <= serial_q ? k_q + CW'(1) : n_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  logic load_out;
  assign load_out = ((state_q == ST_PICK) && serial_q) || (state_q == ST_UPD);

  always_ff @(posedge clk_i) begin
    rd_idx_q <= s_q[IW-1:0];
    if (take) begin
      cand_w_q <= st_rd_data;
      cand_i_q <= rd_idx_q;
    end
    if (out_acc) begin
      prev_w_q <= cand_w_q;
      prev_i_q <= cand_i_q;
    end
    if (load_out) begin
      job_index_o   <= JOB_IDX_W'(cand_i_q);
      job_weight_o  <= cand_w_q;
      worker_o      <= serial_q ? '0 : WORKER_W'(pool_best);
      last_result_o <= last_k;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output both open");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_result_o) |=> in_ready_o) else $error("set not closed");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CW'(cand_i_q) < n_q)) else $error("job index out of set");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |-> found_q) else $error("scan found no job");

endmodule
